[rtl/core/address_stride_run_detector_unit_defines.svh]
// assertion macros used by the checker file
`ifndef ADDRESS_STRIDE_RUN_DETECTOR_UNIT_DEFINES_SVH
`define ADDRESS_STRIDE_RUN_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is low
`define ASRD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("asrd check failed");

// next-cycle implication, off while reset is low
`define ASRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("asrd check failed");

// next-cycle implication that also holds through reset
`define ASRD_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("asrd reset check failed");

`endif

[rtl/core/asrd_pkg.sv]
// types and constants of the address stride run detector
`timescale 1ns / 1ps
`default_nettype none

package asrd_pkg;

  localparam int COUNT_BITS = 32;

  localparam int IP_W    = 32;
  localparam int PORT_W  = 16;
  localparam int CNT_W   = 32;

  localparam int IN_DATA_W  = 2 * IP_W + 2 * PORT_W;
  localparam int OUT_DATA_W = CNT_W + 4 * IP_W + 4 * PORT_W;

  // largest run before it is sent out on its own
  localparam logic [CNT_W-1:0] COUNT_LIMIT = (COUNT_BITS >= CNT_W) ? {CNT_W{1'b1}} :
    CNT_W'((64'd1 << COUNT_BITS) - 64'd1);

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

endpackage

`default_nettype wire

[rtl/core/address_stride_run_detector_unit.sv]
// Address stride run detector. Folds a stream of connection descriptors into runs where
// source/destination IP and port each advance by a fixed signed stride, and sends one
// summary (length, first values, strides) per finished run. A run ends on a descriptor that
// breaks the progression, on a flush transaction, or when its length reaches the count
// limit. One transaction is taken every clock cycle while in_tready is high; a descriptor
// passes an input register and then the check stage, which compares it with a running
// expected value per field (one add and compare each) and registers the summary of each
// run. in_tready falls only while the result register holds a summary that is not taken.
`timescale 1ns / 1ps
`default_nettype none

module address_stride_run_detector_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // src_ip, dst_ip, src_port, dst_port
  input  wire  [asrd_pkg::IN_DATA_W-1:0] in_tdata,
  // operation
  input  wire                            in_tuser,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // run_length, first_src_ip, src_ip_stride, first_src_port, src_port_stride,
  // first_dst_ip, dst_ip_stride, first_dst_port, dst_port_stride
  output logic [asrd_pkg::OUT_DATA_W-1:0] out_tdata
);
  import asrd_pkg::*;

  // input register
  logic              stg_valid_r;
  op_t               stg_op_r;
  logic [IP_W-1:0]   stg_sip_r, stg_dip_r;
  logic [PORT_W-1:0] stg_sp_r, stg_dp_r;

  // run state
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IP_W-1:0]   sip_base_r, sip_base_nxt, sip_step_r, sip_step_nxt, sip_pred_r, sip_pred_nxt;
  logic [IP_W-1:0]   dip_base_r, dip_base_nxt, dip_step_r, dip_step_nxt, dip_pred_r, dip_pred_nxt;
  logic [PORT_W-1:0] sp_base_r, sp_base_nxt, sp_step_r, sp_step_nxt, sp_pred_r, sp_pred_nxt;
  logic [PORT_W-1:0] dp_base_r, dp_base_nxt, dp_step_r, dp_step_nxt, dp_pred_r, dp_pred_nxt;

  // result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic go;
  logic match;
  logic emit_old, emit_new;

  assign go         = stg_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !stg_valid_r || !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign match = (stg_sip_r == sip_pred_r) && (stg_dip_r == dip_pred_r) &&
                 (stg_sp_r == sp_pred_r) && (stg_dp_r == dp_pred_r);

  always_comb begin
    cnt_nxt      = cnt_r;
    sip_base_nxt = sip_base_r;
    sip_step_nxt = sip_step_r;
    sip_pred_nxt = sip_pred_r;
    dip_base_nxt = dip_base_r;
    dip_step_nxt = dip_step_r;
    dip_pred_nxt = dip_pred_r;
    sp_base_nxt  = sp_base_r;
    sp_step_nxt  = sp_step_r;
    sp_pred_nxt  = sp_pred_r;
    dp_base_nxt  = dp_base_r;
    dp_step_nxt  = dp_step_r;
    dp_pred_nxt  = dp_pred_r;
    emit_old     = 1'b0;
    emit_new     = 1'b0;
    if (stg_op_r == OP_FLUSH) begin
      if (cnt_r != '0) begin
        emit_old = 1'b1;
        cnt_nxt  = '0;
      end
    end else begin
      if (cnt_r == CNT_W'(1)) begin
        // second item fixes the strides
        sip_step_nxt = stg_sip_r - sip_base_r;
        dip_step_nxt = stg_dip_r - dip_base_r;
        sp_step_nxt  = stg_sp_r - sp_base_r;
        dp_step_nxt  = stg_dp_r - dp_base_r;
        sip_pred_nxt = {stg_sip_r[IP_W-2:0], 1'b0} - sip_base_r;
        dip_pred_nxt = {stg_dip_r[IP_W-2:0], 1'b0} - dip_base_r;
        sp_pred_nxt  = {stg_sp_r[PORT_W-2:0], 1'b0} - sp_base_r;
        dp_pred_nxt  = {stg_dp_r[PORT_W-2:0], 1'b0} - dp_base_r;
        cnt_nxt      = CNT_W'(2);
      end else if (cnt_r != '0 && match) begin
        sip_pred_nxt = sip_pred_r + sip_step_r;
        dip_pred_nxt = dip_pred_r + dip_step_r;
        sp_pred_nxt  = sp_pred_r + sp_step_r;
        dp_pred_nxt  = dp_pred_r + dp_step_r;
        cnt_nxt      = cnt_r + CNT_W'(1);
      end else begin
        // new run: empty detector or broken progression
        emit_old     = (cnt_r != '0);
        sip_base_nxt = stg_sip_r;
        dip_base_nxt = stg_dip_r;
        sp_base_nxt  = stg_sp_r;
        dp_base_nxt  = stg_dp_r;
        sip_step_nxt = '0;
        dip_step_nxt = '0;
        sp_step_nxt  = '0;
        dp_step_nxt  = '0;
        cnt_nxt      = CNT_W'(1);
      end
      if (!emit_old && cnt_nxt >= COUNT_LIMIT) begin
        emit_new = 1'b1;
        cnt_nxt  = '0;
      end
    end
  end

  always_comb begin
    if (emit_new) begin
      out_data_nxt = {dp_step_nxt, dp_base_nxt, dip_step_nxt, dip_base_nxt,
                      sp_step_nxt, sp_base_nxt, sip_step_nxt, sip_base_nxt, COUNT_LIMIT};
    end else begin
      out_data_nxt = {dp_step_r, dp_base_r, dip_step_r, dip_base_r,
                      sp_step_r, sp_base_r, sip_step_r, sip_base_r, cnt_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      stg_op_r  <= op_t'(in_tuser);
      stg_sip_r <= in_tdata[IP_W-1:0];
      stg_dip_r <= in_tdata[2*IP_W-1:IP_W];
      stg_sp_r  <= in_tdata[2*IP_W+PORT_W-1:2*IP_W];
      stg_dp_r  <= in_tdata[IN_DATA_W-1:2*IP_W+PORT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (go) begin
      cnt_r <= cnt_nxt;
    end
    if (go) begin
      sip_base_r <= sip_base_nxt;
      sip_step_r <= sip_step_nxt;
      sip_pred_r <= sip_pred_nxt;
      dip_base_r <= dip_base_nxt;
      dip_step_r <= dip_step_nxt;
      dip_pred_r <= dip_pred_nxt;
      sp_base_r  <= sp_base_nxt;
      sp_step_r  <= sp_step_nxt;
      sp_pred_r  <= sp_pred_nxt;
      dp_base_r  <= dp_base_nxt;
      dp_step_r  <= dp_step_nxt;
      dp_pred_r  <= dp_pred_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= emit_old || emit_new;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (go && (emit_old || emit_new)) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/asrd_checker.sv]
// port checks of the address stride run detector and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "address_stride_run_detector_unit_defines.svh"

module asrd_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [asrd_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import asrd_pkg::*;

  logic [CNT_W-1:0]  len;
  logic [IP_W-1:0]   sip_stride, dip_stride;
  logic [PORT_W-1:0] sp_stride, dp_stride;
  logic              flat;

  assign len        = out_tdata[CNT_W-1:0];
  assign sip_stride = out_tdata[CNT_W+2*IP_W-1:CNT_W+IP_W];
  assign sp_stride  = out_tdata[CNT_W+2*IP_W+2*PORT_W-1:CNT_W+2*IP_W+PORT_W];
  assign dip_stride = out_tdata[CNT_W+4*IP_W+2*PORT_W-1:CNT_W+3*IP_W+2*PORT_W];
  assign dp_stride  = out_tdata[OUT_DATA_W-1:CNT_W+4*IP_W+3*PORT_W];
  assign flat       = sip_stride == '0 && dip_stride == '0 && sp_stride == '0 && dp_stride == '0;

  `ASRD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `ASRD_ASSERT_NOW(a_len_range, out_tvalid, len != '0 && len <= COUNT_LIMIT)
  `ASRD_ASSERT_NOW(a_single_flat, out_tvalid && len == CNT_W'(1), flat)
  `ASRD_ASSERT_ALWAYS(a_reset_idle, !rst_n, !out_tvalid && in_tready)

endmodule

bind address_stride_run_detector_unit asrd_checker u_asrd_checker (.*);

`default_nettype wire
